/* src/rsrt_pkg.sv */
// rejection sampler rate table: shared types, codes and sum arithmetic
// no dependencies; used by the top level
package rsrt_pkg;

    localparam int SUM_W = 40;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_UPDATE = 2'd1,
        CMD_SAMPLE = 2'd2,
        CMD_NOP    = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        STATUS_OK      = 3'd0,
        STATUS_REJECT  = 3'd1,
        STATUS_ZERO    = 3'd2,
        STATUS_FULL    = 3'd3,
        STATUS_EMPTY   = 3'd4,
        STATUS_UNKNOWN = 3'd5
    } status_t;

    // remove old rate with clamp at zero, then add new rate with saturation
    function automatic logic [SUM_W-1:0] sum_replace(
        input logic [SUM_W-1:0] sum,
        input logic [SUM_W-1:0] old_rate,
        input logic [SUM_W-1:0] new_rate
    );
        logic [SUM_W-1:0] base;
        logic [SUM_W:0]   total;
        base  = (sum >= old_rate) ? (sum - old_rate) : '0;
        total = {1'b0, base} + {1'b0, new_rate};
        return total[SUM_W] ? SUM_MAX : total[SUM_W-1:0];
    endfunction

endpackage

/* src/rejection_sampler_rate_table.sv */
// rejection sampler rate table: top level with sequencer and table memories
// depends on rsrt_pkg and rsrt_ram
//
//  channel | dir | handshake                   | payload
//  --------+-----+-----------------------------+-----------------------------------------------
//  item    | in  | item_valid, item_stall      | cmd, handle, rate, random_fraction
//  result  | out | result_valid, result_stall  | status, result_handle, total_rate, live_entries
//
// add, update and unused commands go from accept straight to finish with write back
// a sample try: two dependent ram reads (slot to handle, handle to rate) in ST_SLOT and ST_RATE,
//   each with registered read data, then the exact acceptance compare
// one item is in flight at a time; item_stall is high from accept until the finish cycle
// the finish cycle waits while the result register is full and result_stall is high
// reset clears counts, max rate and sum; table memories are not cleared, and their
//   read data is only used at entries written earlier
module rejection_sampler_rate_table #(
    parameter int CAPACITY  = 256,
    parameter int RATE_BITS = 32,
    parameter int RAND_BITS = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic [1:0]  cmd,
    input  logic [7:0]  handle,
    input  logic [31:0] rate,
    input  logic [31:0] random_fraction,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [2:0]  status,
    output logic [7:0]  result_handle,
    output logic [39:0] total_rate,
    output logic [8:0]  live_entries
);

    localparam int SW     = rsrt_pkg::SUM_W;
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int RW     = (RATE_BITS > 32) ? 32 : RATE_BITS;
    localparam int UW     = (RAND_BITS > 32) ? 32 : RAND_BITS;
    localparam int PROD_W = UW + CNT_W;
    localparam int FW     = (PROD_W < RAND_BITS) ? PROD_W : RAND_BITS;
    localparam int FM_W   = FW + RW;
    localparam int CMP_W  = RW + RAND_BITS;
    localparam int HX_W   = IDX_W + 9;
    localparam int LX_W   = CNT_W + 9;
    localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SLOT,
        ST_RATE,
        ST_FIN
    } state_t;

    // sequencer and result registers
    state_t              state_reg,   state_next;
    logic [CNT_W-1:0]    lc_reg,      lc_next;
    logic [CNT_W-1:0]    issued_reg,  issued_next;
    logic [RW-1:0]       max_reg,     max_next;
    logic [SW-1:0]       sum_reg,     sum_next;
    logic                result_valid_reg;
    rsrt_pkg::status_t   status_reg,  status_next;
    logic [7:0]          res_h_reg,   res_h_next;
    logic [SW-1:0]       total_reg;
    logic [CNT_W-1:0]    live_reg;

    // captured item and sample arithmetic
    rsrt_pkg::cmd_t      cmd_reg;
    logic [7:0]          h_reg;
    logic [RW-1:0]       r_reg;
    logic [PROD_W-1:0]   prod_reg,    prod_next;
    logic [FM_W-1:0]     fmul_reg,    fmul_next;

    // ram ports
    logic                rate_we,  rate_re;
    logic [IDX_W-1:0]    rate_waddr, rate_raddr;
    logic [RW-1:0]       rate_wdata, rate_rdata;
    logic                slot_we,  slot_re;
    logic [IDX_W-1:0]    slot_waddr, slot_raddr;
    logic [IDX_W-1:0]    slot_wdata, slot_rdata;
    logic                has_we,   has_re;
    logic [IDX_W-1:0]    has_waddr, has_raddr;
    logic [IDX_W-1:0]    has_wdata, has_rdata;

    // helpers
    logic                accept;
    logic                can_finish;
    rsrt_pkg::cmd_t      cmd_in;
    logic [HX_W-1:0]     handle_x, h_reg_x, nh_x, ch_x;
    logic [IDX_W-1:0]    handle_idx, h_idx, nh_idx, lc_idx, last_idx;
    logic [CNT_W-1:0]    last_cnt;
    logic [PROD_W-1:0]   pos_full;
    logic [IDX_W-1:0]    pos_idx;
    logic [FW-1:0]       frac;
    logic [CMP_W-1:0]    cmp_lhs, cmp_rhs;
    logic [LX_W-1:0]     live_x;

    assign cmd_in     = rsrt_pkg::cmd_t'(cmd);
    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;
    assign can_finish = !result_valid_reg || !result_stall;

    assign handle_x   = HX_W'(handle);
    assign handle_idx = handle_x[IDX_W-1:0];
    assign h_reg_x    = HX_W'(h_reg);
    assign h_idx      = h_reg_x[IDX_W-1:0];
    assign nh_x       = HX_W'(issued_reg);
    assign nh_idx     = nh_x[IDX_W-1:0];
    assign lc_idx     = lc_reg[IDX_W-1:0];
    assign last_cnt   = lc_reg - 1'b1;
    assign last_idx   = last_cnt[IDX_W-1:0];
    assign ch_x       = HX_W'(has_rdata);

    // slot and fraction from u * live_count
    assign prod_next  = PROD_W'(random_fraction[UW-1:0]) * PROD_W'(lc_reg);
    assign pos_full   = prod_reg >> RAND_BITS;
    assign pos_idx    = pos_full[IDX_W-1:0];
    assign frac       = prod_reg[FW-1:0];
    assign fmul_next  = FM_W'(frac) * FM_W'(max_reg);

    // exact compare: rate * 2^RAND_BITS against frac * max_rate
    assign cmp_lhs    = {rate_rdata, {RAND_BITS{1'b0}}};
    assign cmp_rhs    = CMP_W'(fmul_reg);

    // read ports: update reads at accept, sample reads in its own states
    always_comb
    begin
        rate_re    = 1'b0;
        rate_raddr = handle_idx;
        slot_re    = 1'b0;
        slot_raddr = handle_idx;
        has_re     = 1'b0;
        has_raddr  = last_idx;
        if (accept && (cmd_in == rsrt_pkg::CMD_UPDATE))
        begin
            rate_re = 1'b1;
            slot_re = 1'b1;
            has_re  = 1'b1;
        end
        else if (state_reg == ST_SLOT)
        begin
            has_re    = 1'b1;
            has_raddr = pos_idx;
        end
        else if (state_reg == ST_RATE)
        begin
            rate_re    = 1'b1;
            rate_raddr = has_rdata;
        end
    end

    // finish: result, counters and write back
    always_comb
    begin
        lc_next     = lc_reg;
        issued_next = issued_reg;
        max_next    = max_reg;
        sum_next    = sum_reg;
        status_next = rsrt_pkg::STATUS_OK;
        res_h_next  = '0;
        rate_we     = 1'b0;
        rate_waddr  = h_idx;
        rate_wdata  = r_reg;
        slot_we     = 1'b0;
        slot_waddr  = h_idx;
        slot_wdata  = lc_idx;
        has_we      = 1'b0;
        has_waddr   = lc_idx;
        has_wdata   = h_idx;
        if ((state_reg == ST_FIN) && can_finish)
        begin
            unique case (cmd_reg)
                rsrt_pkg::CMD_ADD:
                begin
                    if (r_reg == '0)
                    begin
                        status_next = rsrt_pkg::STATUS_ZERO;
                    end
                    else if ((issued_reg >= CAP_C) || (lc_reg >= CAP_C))
                    begin
                        status_next = rsrt_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        rate_we     = 1'b1;
                        rate_waddr  = nh_idx;
                        slot_we     = 1'b1;
                        slot_waddr  = nh_idx;
                        has_we      = 1'b1;
                        has_wdata   = nh_idx;
                        issued_next = issued_reg + 1'b1;
                        lc_next     = lc_reg + 1'b1;
                        if (r_reg > max_reg)
                        begin
                            max_next = r_reg;
                        end
                        sum_next    = rsrt_pkg::sum_replace(sum_reg, '0, SW'(r_reg));
                        res_h_next  = nh_x[7:0];
                    end
                end
                rsrt_pkg::CMD_UPDATE:
                begin
                    if (h_reg_x >= HX_W'(issued_reg))
                    begin
                        status_next = rsrt_pkg::STATUS_UNKNOWN;
                    end
                    else if (r_reg == '0)
                    begin
                        // delete: move last slot into the freed slot
                        if ((rate_rdata != '0) && (lc_reg != '0))
                        begin
                            has_we     = 1'b1;
                            has_waddr  = slot_rdata;
                            has_wdata  = has_rdata;
                            slot_we    = 1'b1;
                            slot_waddr = has_rdata;
                            slot_wdata = slot_rdata;
                            rate_we    = 1'b1;
                            lc_next    = last_cnt;
                            sum_next   = rsrt_pkg::sum_replace(sum_reg, SW'(rate_rdata), '0);
                        end
                    end
                    else
                    begin
                        if (r_reg > max_reg)
                        begin
                            max_next = r_reg;
                        end
                        // removed handle comes back at the end
                        if ((rate_rdata == '0) && (lc_reg < CAP_C))
                        begin
                            slot_we = 1'b1;
                            has_we  = 1'b1;
                            lc_next = lc_reg + 1'b1;
                        end
                        rate_we  = 1'b1;
                        sum_next = rsrt_pkg::sum_replace(sum_reg, SW'(rate_rdata), SW'(r_reg));
                    end
                end
                rsrt_pkg::CMD_SAMPLE:
                begin
                    if (lc_reg == '0)
                    begin
                        status_next = rsrt_pkg::STATUS_EMPTY;
                    end
                    else if (cmp_lhs > cmp_rhs)
                    begin
                        res_h_next = ch_x[7:0];
                    end
                    else
                    begin
                        status_next = rsrt_pkg::STATUS_REJECT;
                    end
                end
                rsrt_pkg::CMD_NOP:
                begin
                    status_next = rsrt_pkg::STATUS_OK;
                end
            endcase
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if ((cmd_in == rsrt_pkg::CMD_SAMPLE) && (lc_reg != '0))
                    begin
                        state_next = ST_SLOT;
                    end
                    else
                    begin
                        state_next = ST_FIN;
                    end
                end
            end
            ST_SLOT:
            begin
                state_next = ST_RATE;
            end
            ST_RATE:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (can_finish)
                begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            lc_reg           <= '0;
            issued_reg       <= '0;
            max_reg          <= '0;
            sum_reg          <= '0;
            result_valid_reg <= 1'b0;
            status_reg       <= rsrt_pkg::STATUS_OK;
            res_h_reg        <= '0;
            total_reg        <= '0;
            live_reg         <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            lc_reg     <= lc_next;
            issued_reg <= issued_next;
            max_reg    <= max_next;
            sum_reg    <= sum_next;
            if ((state_reg == ST_FIN) && can_finish)
            begin
                result_valid_reg <= 1'b1;
                status_reg       <= status_next;
                res_h_reg        <= res_h_next;
                total_reg        <= sum_next;
                live_reg         <= lc_next;
            end
            else if (result_valid_reg && !result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= cmd_in;
            h_reg    <= handle;
            r_reg    <= rate[RW-1:0];
            prod_reg <= prod_next;
        end
        if (state_reg == ST_RATE)
        begin
            fmul_reg <= fmul_next;
        end
    end

    // rate of each handle
    rsrt_ram #(
        .WIDTH (RW),
        .DEPTH (CAPACITY)
    ) u_rate_ram (
        .clk   (clk),
        .we    (rate_we),
        .waddr (rate_waddr),
        .wdata (rate_wdata),
        .re    (rate_re),
        .raddr (rate_raddr),
        .rdata (rate_rdata)
    );

    // slot of each handle
    rsrt_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CAPACITY)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (slot_re),
        .raddr (slot_raddr),
        .rdata (slot_rdata)
    );

    // handle at each slot
    rsrt_ram #(
        .WIDTH (IDX_W),
        .DEPTH (CAPACITY)
    ) u_has_ram (
        .clk   (clk),
        .we    (has_we),
        .waddr (has_waddr),
        .wdata (has_wdata),
        .re    (has_re),
        .raddr (has_raddr),
        .rdata (has_rdata)
    );

    assign live_x        = LX_W'(live_reg);
    assign result_valid  = result_valid_reg;
    assign status        = status_reg;
    assign result_handle = res_h_reg;
    assign total_rate    = total_reg;
    assign live_entries  = live_x[8:0];

`ifndef SYNTH
    a_live_le_issued: assert property (@(posedge clk) disable iff (!rst_n)
        lc_reg <= issued_reg)
        else $error("live count exceeds issued handles");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_FIN))
        else $error("result transfer raised outside finish");

    a_count_moves_at_finish: assert property (@(posedge clk) disable iff (!rst_n)
        (lc_reg != $past(lc_reg)) |-> $past(state_reg == ST_FIN))
        else $error("live count changed outside finish");

    a_max_never_falls: assert property (@(posedge clk) disable iff (!rst_n)
        max_reg >= $past(max_reg))
        else $error("max rate fell");
`endif

endmodule

/* src/rsrt_ram.sv */
// rejection sampler rate table: generic ram, one write and one read port
// registered read data that holds while read enable is low; no dependencies
module rsrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
